// ===== design/isotp_rx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_rx_pkg
// Shared constants, codes, types and helpers of the iso-tp receive reassembler.
// ----------------------------------------------------------------------------
package isotp_rx_pkg;

  localparam int MAX_MESSAGE_BYTES = 256;
  localparam int ADDR_W            = $clog2(MAX_MESSAGE_BYTES);
  localparam int RAM_DEPTH         = 2 ** ADDR_W;

  localparam int ID_W       = 29;
  localparam int PAY_W      = 64;
  localparam int LEN_W      = 10;
  localparam int SEQ_W      = 4;
  localparam int TMO_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [1:0]            kind_t;
  typedef logic [ID_W-1:0]       id_t;
  typedef logic [PAY_W-1:0]      pay_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // input item kinds
  localparam kind_t KIND_FRAME = 2'd0;
  localparam kind_t KIND_TICK  = 2'd1;
  localparam kind_t KIND_FETCH = 2'd2;
  localparam kind_t KIND_NOP   = 2'd3;

  // result kinds
  localparam kind_t RES_FC    = 2'd0;
  localparam kind_t RES_CHUNK = 2'd1;
  localparam kind_t RES_NONE  = 2'd2;

  // protocol control info types (high nibble of byte 0)
  localparam logic [3:0] PCI_SINGLE = 4'h0;
  localparam logic [3:0] PCI_FIRST  = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;

  // configuration register indexes
  localparam cfg_idx_t REG_SEND_WAIT = 2'd0;
  localparam cfg_idx_t REG_TIMEOUT   = 2'd1;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]       FC_CTS        = 8'h30;
  localparam logic [7:0]       FC_WAIT       = 8'h31;
  localparam logic [39:0]      FC_FILL       = 40'hAA_AAAA_AAAA;
  localparam logic [11:0]      MAX_FF_LEN    = 12'(MAX_MESSAGE_BYTES);
  localparam logic [11:0]      MIN_FF_LEN    = 12'd8;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // byte k of a frame payload, byte 0 in the top bits
  function automatic logic [7:0] byte_of(input pay_t pay, input logic [2:0] k);
    logic [5:0] sh;
    sh = {~k, 3'b000};
    return pay[sh +: 8];
  endfunction

endpackage

// ===== design/isotp_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_rx_if
// Valid/ready channels: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface isotp_rx_in_if;
  import isotp_rx_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  id_t   frame_id;
  logic  is_extended;
  pay_t  frame_payload;

  modport source (output valid, kind, frame_id, is_extended, frame_payload, input ready);
  modport sink   (input valid, kind, frame_id, is_extended, frame_payload, output ready);
endinterface

interface isotp_rx_out_if;
  import isotp_rx_pkg::*;
  logic  valid;
  logic  ready;
  kind_t result_kind;
  id_t   out_id;
  logic  out_extended;
  pay_t  out_payload;
  len_t  message_length;
  logic  last;

  modport source (output valid, result_kind, out_id, out_extended, out_payload,
                  message_length, last, input ready);
  modport sink   (input valid, result_kind, out_id, out_extended, out_payload,
                  message_length, last, output ready);
endinterface

interface isotp_rx_cfg_if;
  import isotp_rx_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/isotp_rx_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_rx_ram
// Message byte buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module isotp_rx_ram (
  input  logic                   clk,
  input  isotp_rx_pkg::ram_req_t req,
  output logic [7:0]             rdata
);
  import isotp_rx_pkg::*;

  logic [7:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== design/isotp_rx_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_rx_ctrl
// Frame decode, reassembly bookkeeping, buffer sequencing and result register.
// ----------------------------------------------------------------------------
module isotp_rx_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  isotp_rx_in_if.sink            in_if,
  isotp_rx_out_if.source         out_if,
  isotp_rx_cfg_if.sink           cfg_if,
  output isotp_rx_pkg::ram_req_t ram_req,
  input  logic [7:0]             ram_rdata
);
  import isotp_rx_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_EMIT  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CHUNK = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic              send_wait_r, send_wait_nxt;
  logic [TMO_W-1:0]  tmo_r, tmo_nxt;
  logic              receiving_r, receiving_nxt;
  id_t               msg_id_r, msg_id_nxt;
  len_t              count_r, count_nxt;
  len_t              ann_r, ann_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic [TMO_W-1:0]  idle_r, idle_nxt;

  pay_t              pay_r, pay_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [2:0]        wr_src_r, wr_src_nxt;
  logic [2:0]        wr_left_r, wr_left_nxt;
  logic              emit_after_r, emit_after_nxt;
  kind_t             res_kind_r, res_kind_nxt;
  id_t               res_id_r, res_id_nxt;
  logic              res_ext_r, res_ext_nxt;
  pay_t              res_pay_r, res_pay_nxt;

  len_t              chunk_base_r, chunk_base_nxt;
  logic [3:0]        rd_j_r, rd_j_nxt;
  logic              keep_r, keep_nxt;
  pay_t              chunk_r, chunk_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  id_t               out_id_r, out_id_nxt;
  logic              out_ext_r, out_ext_nxt;
  pay_t              out_pay_r, out_pay_nxt;
  len_t              out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;

  logic [7:0]        b0;
  logic [3:0]        pci;
  logic [11:0]       ff_len;
  len_t              remain;
  logic [2:0]        cf_n;
  len_t              cf_count;
  logic [TMO_W-1:0]  idle_inc;
  id_t               reply_id;
  len_t              rd_pos;
  len_t              next_base;
  logic              slot_free;

  assign in_if.ready           = (state_r == ST_IDLE);
  assign cfg_if.ready          = 1'b1;
  assign out_if.valid          = out_valid_r;
  assign out_if.result_kind    = out_kind_r;
  assign out_if.out_id         = out_id_r;
  assign out_if.out_extended   = out_ext_r;
  assign out_if.out_payload    = out_pay_r;
  assign out_if.message_length = out_len_r;
  assign out_if.last           = out_last_r;

  always_comb begin
    b0        = in_if.frame_payload[PAY_W-1 -: 8];
    pci       = b0[7:4];
    ff_len    = {b0[3:0], byte_of(in_if.frame_payload, 3'd1)};
    remain    = (ann_r > count_r) ? (ann_r - count_r) : '0;
    cf_n      = (remain > len_t'(7)) ? 3'd7 : remain[2:0];
    cf_count  = count_r + len_t'(cf_n);
    idle_inc  = (idle_r == '1) ? idle_r : idle_r + 16'd1;
    reply_id  = in_if.is_extended
              ? {in_if.frame_id[ID_W-1:16], in_if.frame_id[7:0], in_if.frame_id[15:8]}
              : in_if.frame_id + 29'd8;
    rd_pos    = chunk_base_r + len_t'(rd_j_r);
    next_base = chunk_base_r + len_t'(8);
    slot_free = !out_valid_r || out_if.ready;

    state_nxt      = state_r;
    send_wait_nxt  = send_wait_r;
    tmo_nxt        = tmo_r;
    receiving_nxt  = receiving_r;
    msg_id_nxt     = msg_id_r;
    count_nxt      = count_r;
    ann_nxt        = ann_r;
    seq_nxt        = seq_r;
    idle_nxt       = idle_r;
    pay_nxt        = pay_r;
    wr_addr_nxt    = wr_addr_r;
    wr_src_nxt     = wr_src_r;
    wr_left_nxt    = wr_left_r;
    emit_after_nxt = emit_after_r;
    res_kind_nxt   = res_kind_r;
    res_id_nxt     = res_id_r;
    res_ext_nxt    = res_ext_r;
    res_pay_nxt    = res_pay_r;
    chunk_base_nxt = chunk_base_r;
    rd_j_nxt       = rd_j_r;
    keep_nxt       = keep_r;
    chunk_nxt      = chunk_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_id_nxt     = out_id_r;
    out_ext_nxt    = out_ext_r;
    out_pay_nxt    = out_pay_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;

    ram_req.we    = 1'b0;
    ram_req.waddr = wr_addr_r;
    ram_req.wdata = byte_of(pay_r, wr_src_r);
    ram_req.raddr = rd_pos[ADDR_W-1:0];

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_if.valid) begin
      if (cfg_if.index == REG_SEND_WAIT) begin
        send_wait_nxt = cfg_if.data[0];
      end else if (cfg_if.index == REG_TIMEOUT) begin
        tmo_nxt = cfg_if.data;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          pay_nxt = in_if.frame_payload;
          unique case (in_if.kind)
            KIND_FRAME: begin
              if (pci == PCI_SINGLE) begin
                receiving_nxt = 1'b0;
                count_nxt     = '0;
                if (b0[3:0] != 4'd0 && b0[3:0] <= 4'd7) begin
                  msg_id_nxt     = in_if.frame_id;
                  ann_nxt        = '0;
                  count_nxt      = len_t'(b0[2:0]);
                  wr_addr_nxt    = '0;
                  wr_src_nxt     = 3'd1;
                  wr_left_nxt    = b0[2:0];
                  emit_after_nxt = 1'b0;
                  state_nxt      = ST_WRITE;
                end
              end else if (pci == PCI_FIRST) begin
                if (ff_len <= MAX_FF_LEN && ff_len >= MIN_FF_LEN) begin
                  msg_id_nxt     = in_if.frame_id;
                  count_nxt      = len_t'(6);
                  ann_nxt        = ff_len[LEN_W-1:0];
                  seq_nxt        = 4'd1;
                  receiving_nxt  = 1'b1;
                  idle_nxt       = '0;
                  wr_addr_nxt    = '0;
                  wr_src_nxt     = 3'd2;
                  wr_left_nxt    = 3'd6;
                  emit_after_nxt = 1'b1;
                  res_kind_nxt   = RES_FC;
                  res_id_nxt     = reply_id;
                  res_ext_nxt    = in_if.is_extended;
                  res_pay_nxt    = {send_wait_r ? FC_WAIT : FC_CTS, 16'h0000, FC_FILL};
                  state_nxt      = ST_WRITE;
                end
              end else if (pci == PCI_CONSEC) begin
                if (receiving_r && in_if.frame_id == msg_id_r) begin
                  if (b0[3:0] != seq_r) begin
                    receiving_nxt = 1'b0;
                    count_nxt     = '0;
                  end else begin
                    wr_addr_nxt    = count_r[ADDR_W-1:0];
                    wr_src_nxt     = 3'd1;
                    wr_left_nxt    = cf_n;
                    emit_after_nxt = 1'b0;
                    count_nxt      = cf_count;
                    seq_nxt        = seq_r + 4'd1;
                    idle_nxt       = '0;
                    if (cf_count >= ann_r) begin
                      receiving_nxt = 1'b0;
                    end
                    if (cf_n != 3'd0) begin
                      state_nxt = ST_WRITE;
                    end
                  end
                end
              end
            end
            KIND_TICK: begin
              if (receiving_r) begin
                idle_nxt = idle_inc;
                if (idle_inc > tmo_r) begin
                  receiving_nxt = 1'b0;
                  count_nxt     = '0;
                end
              end
            end
            KIND_FETCH: begin
              if (count_r == '0 || receiving_r) begin
                res_kind_nxt = RES_NONE;
                res_id_nxt   = '0;
                res_ext_nxt  = 1'b0;
                res_pay_nxt  = '0;
                state_nxt    = ST_EMIT;
              end else begin
                chunk_base_nxt = '0;
                rd_j_nxt       = '0;
                state_nxt      = ST_READ;
              end
            end
            KIND_NOP: begin
            end
          endcase
        end
      end

      // one buffer byte per cycle
      ST_WRITE: begin
        ram_req.we  = 1'b1;
        wr_addr_nxt = wr_addr_r + ADDR_W'(1);
        wr_src_nxt  = wr_src_r + 3'd1;
        wr_left_nxt = wr_left_r - 3'd1;
        if (wr_left_r == 3'd1) begin
          state_nxt = emit_after_r ? ST_EMIT : ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_id_nxt    = res_id_r;
          out_ext_nxt   = res_ext_r;
          out_pay_nxt   = res_pay_r;
          out_len_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      // address issued at step j, data collected at step j+1
      ST_READ: begin
        if (rd_j_r != 4'd8) begin
          keep_nxt = (rd_pos < count_r);
        end
        if (rd_j_r != 4'd0) begin
          chunk_nxt = {chunk_r[PAY_W-9:0], keep_r ? ram_rdata : 8'h00};
        end
        rd_j_nxt = rd_j_r + 4'd1;
        if (rd_j_r == 4'd8) begin
          state_nxt = ST_CHUNK;
        end
      end

      ST_CHUNK: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = RES_CHUNK;
          out_id_nxt    = msg_id_r;
          out_ext_nxt   = 1'b0;
          out_pay_nxt   = chunk_r;
          out_len_nxt   = count_r;
          out_last_nxt  = (next_base >= count_r);
          if (next_base >= count_r) begin
            count_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            chunk_base_nxt = next_base;
            rd_j_nxt       = '0;
            state_nxt      = ST_READ;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      send_wait_r <= 1'b0;
      tmo_r       <= TIMEOUT_RESET;
      receiving_r <= 1'b0;
      msg_id_r    <= '0;
      count_r     <= '0;
      ann_r       <= '0;
      seq_r       <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      send_wait_r <= send_wait_nxt;
      tmo_r       <= tmo_nxt;
      receiving_r <= receiving_nxt;
      msg_id_r    <= msg_id_nxt;
      count_r     <= count_nxt;
      ann_r       <= ann_nxt;
      seq_r       <= seq_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pay_r        <= pay_nxt;
    wr_addr_r    <= wr_addr_nxt;
    wr_src_r     <= wr_src_nxt;
    wr_left_r    <= wr_left_nxt;
    emit_after_r <= emit_after_nxt;
    res_kind_r   <= res_kind_nxt;
    res_id_r     <= res_id_nxt;
    res_ext_r    <= res_ext_nxt;
    res_pay_r    <= res_pay_nxt;
    chunk_base_r <= chunk_base_nxt;
    rd_j_r       <= rd_j_nxt;
    keep_r       <= keep_nxt;
    chunk_r      <= chunk_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_ext_r    <= out_ext_nxt;
    out_pay_r    <= out_pay_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// ===== design/isotp_receive_reassembler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_receive_reassembler_unit
// ISO-TP receive side: reassembles CAN frames into messages held in a byte RAM.
// ----------------------------------------------------------------------------
// Items are handled one at a time; the message bytes live in a single-port-
// write byte RAM, so an accepted frame stores its bytes one per cycle and a
// first frame then posts its flow control beat. A fetch reads the RAM one
// byte per cycle within a chunk, 8 bytes to a chunk, ceil(length/8) chunks in
// all, each chunk waiting for a free result register. The result register lets
// a new item be accepted while a beat waits on the output. Both registers may
// be written at any cycle the block is idle.
module isotp_receive_reassembler_unit (
  input  logic           clk,
  input  logic           rst_n,
  isotp_rx_in_if.sink    in_if,
  isotp_rx_out_if.source out_if,
  isotp_rx_cfg_if.sink   cfg_if
);
  import isotp_rx_pkg::*;

  ram_req_t   ram_req;
  logic [7:0] ram_rdata;

  isotp_rx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_if    (cfg_if),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  isotp_rx_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

// ===== design/isotp_rx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_rx_checker
// Port-level checks on result beats of the iso-tp receive reassembler.
// ----------------------------------------------------------------------------
module isotp_rx_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input isotp_rx_pkg::kind_t out_kind,
  input isotp_rx_pkg::id_t   out_id,
  input logic                out_ext,
  input isotp_rx_pkg::pay_t  out_pay,
  input isotp_rx_pkg::len_t  out_len,
  input logic                out_last
);
  import isotp_rx_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pay) && $stable(out_kind))
    else $error("result beat changed while stalled");

  a_fc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == RES_FC |->
      out_last && out_len == '0 && out_pay[55:0] == {16'h0000, FC_FILL})
    else $error("malformed flow control beat");

  a_none_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == RES_NONE |->
      out_last && out_id == '0 && !out_ext && out_pay == '0 && out_len == '0)
    else $error("malformed no-message beat");

  a_chunk_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == RES_CHUNK |-> !out_ext && out_len != '0)
    else $error("malformed chunk beat");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind isotp_receive_reassembler_unit isotp_rx_checker u_isotp_rx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_kind  (out_if.result_kind),
  .out_id    (out_if.out_id),
  .out_ext   (out_if.out_extended),
  .out_pay   (out_if.out_payload),
  .out_len   (out_if.message_length),
  .out_last  (out_if.last)
);
